/* rtl/core/mexp_pkg.sv */
// Shared types for the modular exponentiation core: cell chain, select and control signals.
package mexp_pkg;

	// Ripple signals passed from one bit cell to the next higher one
	typedef struct packed {
		logic c1;  // carry of the doubling sum
		logic b1;  // borrow of the doubling sum minus modulus
		logic c2;  // carry of the addend sum
		logic b2;  // borrow of the addend sum minus modulus
	} chain_t;

	// Row-wide choice between the raw sum and the sum minus modulus
	typedef struct packed {
		logic s1;  // doubling row takes the reduced value
		logic s2;  // addend row takes the reduced value
	} sel_t;

	// Row-wide register control
	typedef struct packed {
		logic load;  // overwrite the bit with the load value
		logic en;    // take the stepped value
	} ctl_t;

endpackage

/* rtl/core/mexp_cell.sv */
// One bit slice of the modular accumulator: double, add, and conditional subtract.
module mexp_cell (
	input  logic             clk,
	input  mexp_pkg::ctl_t   ctl,
	input  logic             ld_bit,
	input  logic             x_bit,
	input  logic             n_bit,
	input  mexp_pkg::chain_t cin,
	output mexp_pkg::chain_t cout,
	input  mexp_pkg::sel_t   sel,
	output logic             q
);

	logic acc_q;
	logic s1, d1, r1, s2, d2, r2;

	// Doubling row (acc + acc, then minus modulus) and addend row
	// (doubled value + addend, then minus modulus)
	always_comb begin
		s1      = acc_q ^ acc_q ^ cin.c1;
		cout.c1 = (acc_q & acc_q) | (cin.c1 & (acc_q ^ acc_q));
		d1      = s1 ^ n_bit ^ cin.b1;
		cout.b1 = (~s1 & n_bit) | (~(s1 ^ n_bit) & cin.b1);
		r1      = sel.s1 ? d1 : s1;
		s2      = r1 ^ x_bit ^ cin.c2;
		cout.c2 = (r1 & x_bit) | (cin.c2 & (r1 ^ x_bit));
		d2      = s2 ^ n_bit ^ cin.b2;
		cout.b2 = (~s2 & n_bit) | (~(s2 ^ n_bit) & cin.b2);
		r2      = sel.s2 ? d2 : s2;
	end

	// Accumulator bit
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			acc_q <= ld_bit;
		end else if (ctl.en) begin
			acc_q <= r2;
		end
	end

	assign q = acc_q;

endmodule

/* rtl/core/modular_exponentiation_core.sv */
// Top level of the modular exponentiation core: control sequencer and row of bit cells.
// Computes base ** exponent mod modulus by left-to-right square-and-multiply. Each
// modular product runs through a row of WORD_BITS bit cells that double the
// accumulator and add the multiplicand once per cycle, with ripple carry and borrow
// chains between neighboring cells. The base is first reduced modulo the modulus;
// then per exponent bit a squaring runs and, when the bit is set, a multiply follows.
// One item is in work at a time; a finished residue waits in an output register while
// the next item is accepted. Modulus writes are taken at any time but must only happen
// while idle.
module modular_exponentiation_core #(
	parameter int WORD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] base,
	input  logic [31:0] exponent,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] residue
);

	localparam int CW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RED   = 3'd1;
	localparam logic [2:0] ST_INIT  = 3'd2;
	localparam logic [2:0] ST_SQSET = 3'd3;
	localparam logic [2:0] ST_RUN   = 3'd4;
	localparam logic [2:0] ST_AFTER = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	logic [2:0]           state_q;
	logic [WORD_BITS-1:0] n_q, bred_q, a_q, m_q, e_q;
	logic [CW-1:0]        cnt_q, ecnt_q;
	logic                 isq_q, red_q;
	logic                 out_valid_q;
	logic [31:0]          res_q;

	logic [WORD_BITS-1:0] acc, ld_vec, x_vec;
	mexp_pkg::chain_t     chain [WORD_BITS+1];
	mexp_pkg::sel_t       sel;
	mexp_pkg::ctl_t       ctl;
	logic                 fin_ok;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign residue   = res_q;
	assign fin_ok    = !out_valid_q || out_ready;

	// Row-wide reduce selects from the top of the chains
	assign chain[0] = '0;
	assign sel.s1   = chain[WORD_BITS].c1 | ~chain[WORD_BITS].b1;
	assign sel.s2   = chain[WORD_BITS].c2 | ~chain[WORD_BITS].b2;

	// Addend: base bit while reducing, multiplicand when the multiplier bit is set
	always_comb begin
		x_vec = '0;
		if (red_q) begin
			x_vec[0] = m_q[WORD_BITS-1];
		end else if (m_q[WORD_BITS-1]) begin
			x_vec = a_q;
		end
	end

	// Load value and cell control
	always_comb begin
		ld_vec   = '0;
		ctl.load = 1'b0;
		ctl.en   = (state_q == ST_RUN);
		case (state_q)
			ST_IDLE: ctl.load = in_valid;
			ST_INIT: begin
				ctl.load  = 1'b1;
				ld_vec[0] = (n_q != WORD_BITS'(1));
			end
			ST_SQSET: ctl.load = 1'b1;
			ST_AFTER: ctl.load = isq_q && e_q[WORD_BITS-1];
			default: ;
		endcase
	end

	// Row of bit cells
	for (genvar i = 0; i < WORD_BITS; i++) begin : g_cell
		mexp_cell u_cell (
			.clk    (clk),
			.ctl    (ctl),
			.ld_bit (ld_vec[i]),
			.x_bit  (x_vec[i]),
			.n_bit  (n_q[i]),
			.cin    (chain[i]),
			.cout   (chain[i+1]),
			.sel    (sel),
			.q      (acc[i])
		);
	end

	// Modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= WORD_BITS'(1);
		end else if (cfg_valid) begin
			n_q <= WORD_BITS'(cfg_data);
		end
	end

	// Output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && fin_ok) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			isq_q       <= 1'b0;
			red_q       <= 1'b0;
			cnt_q       <= '0;
			ecnt_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						m_q     <= WORD_BITS'(base);
						e_q     <= WORD_BITS'(exponent);
						red_q   <= 1'b1;
						cnt_q   <= CW'(WORD_BITS - 1);
						state_q <= ST_RUN;
					end
				end
				ST_INIT: begin
					bred_q  <= acc;
					ecnt_q  <= CW'(WORD_BITS - 1);
					state_q <= ST_SQSET;
				end
				ST_SQSET: begin
					a_q     <= acc;
					m_q     <= acc;
					isq_q   <= 1'b1;
					cnt_q   <= CW'(WORD_BITS - 1);
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					m_q   <= m_q << 1;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						if (red_q) begin
							red_q   <= 1'b0;
							state_q <= ST_INIT;
						end else begin
							state_q <= ST_AFTER;
						end
					end
				end
				ST_AFTER: begin
					if (isq_q && e_q[WORD_BITS-1]) begin
						a_q     <= bred_q;
						m_q     <= acc;
						isq_q   <= 1'b0;
						cnt_q   <= CW'(WORD_BITS - 1);
						state_q <= ST_RUN;
					end else begin
						e_q <= e_q << 1;
						if (ecnt_q == '0) begin
							state_q <= ST_OUT;
						end else begin
							ecnt_q  <= ecnt_q - 1'b1;
							state_q <= ST_SQSET;
						end
					end
				end
				ST_OUT: begin
					if (fin_ok) begin
						res_q       <= (n_q == '0) ? 32'd0 : 32'(acc);
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* tb/sv/tb_top.sv */
// Testbench for the modular exponentiation core: scoreboard, drivers and run control.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// Expected residues and their comparison against the core's output
	class residue_board;
		logic [31:0] modulus_q;
		logic [31:0] pending_q[$];
		int errors;
		int reported;

		function new();
			modulus_q = 32'd1;
			errors = 0;
			reported = 0;
		endfunction

		// base ** exponent mod n, reducing after every product
		function logic [31:0] pow_mod(logic [31:0] b, logic [31:0] e,
			logic [31:0] n);
			logic [63:0] acc;
			logic [63:0] bb;
			if (n == 0)
				return 32'd0;
			acc = 64'd1 % n;
			bb = b % n;
			for (int i = 31; i >= 0; i--) begin
				acc = (acc * acc) % n;
				if (e[i])
					acc = (acc * bb) % n;
			end
			return acc[31:0];
		endfunction

		function void note_word(logic [31:0] b, logic [31:0] e);
			pending_q.push_back(pow_mod(b, e, modulus_q));
		endfunction

		function void check_word(logic [31:0] r);
			logic [31:0] want;
			if (pending_q.size() == 0) begin
				errors++;
				if (reported < 10) begin
					reported++;
					$display("unexpected residue %h", r);
				end
				return;
			end
			want = pending_q.pop_front();
			if (want !== r) begin
				errors++;
				if (reported < 10) begin
					reported++;
					$display("residue mismatch: expected %h got %h", want, r);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] base;
	logic [31:0] exponent;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] residue;
	logic        stim_done;
	logic        out_took;
	int          out_wait;

	residue_board board = new();

	modular_exponentiation_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .base(base), .exponent(exponent),
		.out_valid(out_valid), .out_ready(out_ready), .residue(residue)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Write the modulus register; core must be idle
	task automatic write_modulus(logic [31:0] n);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= n;
		do @(posedge clk); while (!cfg_ready);
		board.modulus_q = n;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Send one word after a random gap; valid drops at the start of a gap or in drain
	task automatic send_word(logic [31:0] b, logic [31:0] e);
		int gap;
		gap = $urandom_range(0, 5);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		base <= b;
		exponent <= e;
		do @(posedge clk); while (!in_ready);
		board.note_word(b, e);
		@(negedge clk);
	endtask

	// Wait for every expected residue, then a margin
	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_operand(int mode);
		case (mode)
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	// Receiver: per word, ready rises after a random delay
	always @(negedge clk) begin
		if (arst_n !== 1'b1) begin
			out_ready <= 1'b0;
			out_wait <= $urandom_range(0, 5);
		end else if (out_took) begin
			out_wait = $urandom_range(0, 5);
			if (out_wait == 0) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				out_wait <= out_wait - 1;
			end
		end else if (out_wait != 0) begin
			out_ready <= 1'b0;
			out_wait <= out_wait - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		out_took <= (arst_n === 1'b1) && out_valid && out_ready;
		if (arst_n && out_valid && out_ready)
			board.check_word(residue);
	end

	// Stimulus
	initial begin
		logic [31:0] moduli[8];
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		base = '0;
		exponent = '0;
		stim_done = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset modulus of one: everything is zero
		send_word(32'd5, 32'd3);
		send_word(32'd0, 32'd0);
		drain();

		// Directed: textbook key, extremes, zero exponent, base above modulus
		write_modulus(32'd3233);
		send_word(32'd65, 32'd17);
		send_word(32'd2790, 32'd413);
		send_word(32'd0, 32'd0);
		send_word(32'd7, 32'd0);
		send_word(32'd0, 32'd5);
		send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(32'hFFFF_FFFF, 32'd1);
		send_word(32'd3233, 32'd7);
		drain();
		write_modulus(32'hFFFF_FFFF);
		send_word(32'hFFFF_FFFE, 32'hFFFF_FFFF);
		send_word(32'hFFFF_FFFF, 32'd2);
		send_word(32'h8000_0000, 32'h8000_0001);
		send_word(32'd12345, 32'd0);
		drain();
		write_modulus(32'd0);
		send_word(32'd9, 32'd9);
		drain();
		write_modulus(32'd2);
		send_word(32'd3, 32'hAAAA_AAAA);
		send_word(32'd4, 32'h5555_5555);
		drain();

		// Random phases over several moduli
		moduli[0] = 32'd1;
		moduli[1] = 32'hFFFF_FFFF;
		moduli[2] = 32'hFFFF_FFFB;
		moduli[3] = 32'd3233;
		moduli[4] = 32'h8000_0000;
		for (int p = 5; p < 8; p++)
			moduli[p] = $urandom | 32'd1;
		for (int p = 0; p < 8; p++) begin
			write_modulus(moduli[p]);
			for (int k = 0; k < 32; k++)
				send_word(rand_operand($urandom_range(0, 7)),
					rand_operand($urandom_range(0, 7)));
			drain();
		end
		stim_done = 1'b1;
	end

	// Final verdict
	initial begin
		wait (stim_done);
		if (board.errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	// Watchdog
	initial begin
		#30ms;
		$display("tb_top: FAIL");
		$finish;
	end
endmodule
